// ===== rtl/wge_pkg.sv =====
// shared constants, types and helpers for the wormhole geodesic step block
package wge_pkg;

  localparam int FracBits   = 24;
  localparam int CordicIter = 24;
  localparam int CordicMax  = 30;
  localparam int CordicN    = (CordicIter < CordicMax) ? CordicIter : CordicMax;
  localparam int Q30Shift   = 30 - FracBits;

  localparam logic signed [35:0] TwoPiQ30  = 36'sd6746518852;
  localparam logic signed [35:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [35:0] GainQ30   = 36'sd652032874;

  localparam logic [30:0] ThroatResetVal = 31'(64'd4 << FracBits);
  localparam logic [24:0] StepResetVal   = 25'((64'd1 << FracBits) / 100);

  typedef enum logic [0:0] {
    CFG_THROAT = 1'b0,
    CFG_STEP   = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    MODE_LOAD = 1'b0,
    MODE_STEP = 1'b1
  } mode_e;

  // multiplier / divider operation codes
  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1
  } op_e;

  typedef struct packed {
    logic              start;
    op_e               op;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] res;
    logic               sat;
  } alu_rsp_t;

  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    unique case (i)
      5'd0:  return 36'sd843314857;
      5'd1:  return 36'sd497837829;
      5'd2:  return 36'sd263043837;
      5'd3:  return 36'sd133525159;
      5'd4:  return 36'sd67021687;
      5'd5:  return 36'sd33543516;
      5'd6:  return 36'sd16775851;
      5'd7:  return 36'sd8388437;
      5'd8:  return 36'sd4194283;
      5'd9:  return 36'sd2097149;
      5'd10: return 36'sd1048576;
      5'd11: return 36'sd524288;
      5'd12: return 36'sd262144;
      5'd13: return 36'sd131072;
      5'd14: return 36'sd65536;
      5'd15: return 36'sd32768;
      5'd16: return 36'sd16384;
      5'd17: return 36'sd8192;
      5'd18: return 36'sd4096;
      5'd19: return 36'sd2048;
      5'd20: return 36'sd1024;
      5'd21: return 36'sd512;
      5'd22: return 36'sd256;
      5'd23: return 36'sd128;
      5'd24: return 36'sd64;
      5'd25: return 36'sd32;
      5'd26: return 36'sd16;
      5'd27: return 36'sd8;
      5'd28: return 36'sd4;
      5'd29: return 36'sd2;
      default: return 36'sd0;
    endcase
  endfunction

  // clamp a wide signed value to 32-bit signed
  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic clamp_hit(input logic signed [63:0] v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

endpackage

// ===== rtl/wge_cordic.sv =====
// iterative cordic sine and cosine, one rotation per cycle
module wge_cordic (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [31:0]  theta_i,
  output logic                done_o,
  output logic signed [31:0]  sin_o,
  output logic signed [31:0]  cos_o
);
  import wge_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_FOLD,
    S_REDUCE,
    S_ROT,
    S_OUT
  } state_e;

  state_e             state_q;
  logic [4:0]         iter_q;
  logic [2:0]         k_q;
  logic signed [35:0] x_q, y_q;
  logic signed [39:0] z_q;
  logic               neg_q;
  logic               flip_q;
  logic               done_q;
  logic signed [31:0] sin_q, cos_q;

  logic signed [39:0] zr, zm, two_pi_k, z1, z2;
  logic signed [35:0] xs, ys, xo, yo;

  always_comb begin
    // theta in q10.30, magnitude taken below 2pi by shifted compare and subtract
    zr       = 40'(theta_i) <<< Q30Shift;
    zm       = zr[39] ? -zr : zr;
    two_pi_k = 40'(TwoPiQ30) <<< k_q;
    // remainder keeps the sign of theta, then folds into [-pi, pi]
    z1 = neg_q ? -z_q : z_q;
    if (z1 > 40'(PiQ30)) z2 = z1 - 40'(TwoPiQ30);
    else if (z1 < -40'(PiQ30)) z2 = z1 + 40'(TwoPiQ30);
    else z2 = z1;
    xs = x_q >>> iter_q;
    ys = y_q >>> iter_q;
    xo = flip_q ? -x_q : x_q;
    yo = flip_q ? -y_q : y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      iter_q  <= '0;
      k_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            z_q     <= zm;
            neg_q   <= zr[39];
            // quotient by 2pi stays below 32
            k_q     <= 3'd4;
            state_q <= S_MOD;
          end
        end
        S_MOD: begin
          if (z_q >= two_pi_k) z_q <= z_q - two_pi_k;
          k_q <= k_q - 3'd1;
          if (k_q == 3'd0) state_q <= S_FOLD;
        end
        S_FOLD: begin
          z_q     <= z2;
          state_q <= S_REDUCE;
        end
        S_REDUCE: begin
          x_q    <= GainQ30;
          y_q    <= '0;
          iter_q <= '0;
          flip_q <= 1'b0;
          if (z_q > 40'(HalfPiQ30)) begin
            z_q <= z_q - 40'(PiQ30);
            flip_q <= 1'b1;
          end else if (z_q < -40'(HalfPiQ30)) begin
            z_q <= z_q + 40'(PiQ30);
            flip_q <= 1'b1;
          end
          state_q <= S_ROT;
        end
        S_ROT: begin
          if (z_q >= 0) begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - 40'(atan_q30(iter_q));
          end else begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + 40'(atan_q30(iter_q));
          end
          iter_q <= iter_q + 5'd1;
          if (iter_q == 5'(CordicN - 1)) state_q <= S_OUT;
        end
        S_OUT: begin
          sin_q   <= 32'((yo + (36'sd1 <<< (Q30Shift - 1))) >>> Q30Shift);
          cos_q   <= 32'((xo + (36'sd1 <<< (Q30Shift - 1))) >>> Q30Shift);
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign sin_o  = sin_q;
  assign cos_o  = cos_q;
endmodule

// ===== rtl/wge_alu.sv =====
// shared fixed-point unit: registered multiply or bit-serial restoring divide
module wge_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wge_pkg::alu_req_t req_i,
  output wge_pkg::alu_rsp_t rsp_o
);
  import wge_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FIN
  } state_e;

  state_e             state_q;
  logic signed [63:0] a_q, b_q;
  logic signed [63:0] prod_q;
  logic [63:0]        num_q;
  logic [63:0]        den_q;
  logic [63:0]        rem_q;
  logic [63:0]        quo_q;
  logic               neg_q;
  logic [5:0]         cnt_q;
  logic               is_div_q;
  logic               done_q;
  logic signed [63:0] res_q;
  logic               sat_q;

  logic [64:0]        rem_sh;
  logic signed [63:0] qs, mres;

  always_comb begin
    rem_sh = {rem_q, num_q[63]};
    qs     = neg_q ? -$signed(quo_q) : $signed(quo_q);
    mres   = prod_q >>> FracBits;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (req_i.start) begin
            a_q <= req_i.a;
            b_q <= req_i.b;
            is_div_q <= (req_i.op == OP_DIV);
            if (req_i.op == OP_DIV) begin
              // magnitude of (a << frac) and of b
              num_q <= (req_i.a[63] ? 64'(-req_i.a) : 64'(req_i.a)) << FracBits;
              den_q <= req_i.b[63] ? 64'(-req_i.b) : 64'(req_i.b);
              neg_q <= req_i.a[63] ^ req_i.b[63];
              rem_q <= '0;
              quo_q <= '0;
              cnt_q <= '0;
              state_q <= S_DIV;
            end else begin
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_q  <= $signed(a_q[31:0]) * $signed(b_q[31:0]);
          state_q <= S_FIN;
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, den_q}) begin
            rem_q <= 64'(rem_sh - {1'b0, den_q});
            quo_q <= {quo_q[62:0], 1'b1};
          end else begin
            rem_q <= rem_sh[63:0];
            quo_q <= {quo_q[62:0], 1'b0};
          end
          num_q <= num_q << 1;
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) state_q <= S_FIN;
        end
        S_FIN: begin
          if (is_div_q) begin
            res_q <= 64'(clamp32(qs));
            sat_q <= clamp_hit(qs);
          end else begin
            res_q <= 64'(clamp32(mres));
            sat_q <= clamp_hit(mres);
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;
  assign rsp_o.sat  = sat_q;
endmodule

// ===== rtl/wormhole_geodesic_euler_step_top.sv =====
// top level: state registers, step sequencer and stream ports
// sequence: a load item is emitted in the cycle after acceptance; a step item runs
//   the trigger and cordic, then 21 multiplies and two 64-bit bit-serial divides
//   on the shared unit; a divide is skipped on a zero denominator or zero sine
// throughput: one item at a time; tready is low from acceptance until the
//   result is taken
// reset: asynchronous active low; position and velocity clear to zero,
//   throat_radius_sq to 4.0 and time_step to 0.01
module wormhole_geodesic_euler_step_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  // config write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [0:0]   cfg_index_i,
  input  logic [30:0]  cfg_data_i,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [255:0] s_axis_tdata,  // load_r, load_theta, load_phi, load_ct,
                                      // load_vr, load_vtheta, load_vphi, load_vt
  input  logic         s_axis_tuser,  // mode
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // out_r, out_theta, out_phi, out_ct
  output logic [1:0]   m_axis_tuser   // singular, saturated
);
  import wge_pkg::*;

  // sequencer states, each issued opcode slot waits on the shared unit
  typedef enum logic [2:0] {
    S_IDLE,
    S_TRIG,
    S_CORDIC,
    S_ISSUE,
    S_WAIT,
    S_OUT
  } state_e;

  // micro-op numbers of the step program
  typedef enum logic [4:0] {
    U_S2, U_SC, U_RR, U_Q, U_COT, U_VPH2, U_VTH2, U_S2V, U_AR, U_SCV,
    U_VRVT, U_QA, U_VRVP, U_QB, U_VTVP, U_CB, U_DV0, U_DV1, U_DV2,
    U_DP0, U_DP1, U_DP2, U_DP3, U_DONE
  } uop_e;

  state_e             state_q;
  uop_e               uop_q;
  logic [30:0]        throat_q;
  logic [24:0]        step_q;
  logic signed [31:0] pos_q [4];
  logic signed [31:0] vel_q [4];
  logic signed [31:0] sn_q, cs_q, s2_q, sc_q, q_q, cot_q, vph2_q, t_q;
  logic signed [31:0] acc_q [3];
  logic               sing_q, sat_q;
  logic               ovalid_q;
  logic               cstart;
  logic               cdone;
  logic signed [31:0] csin, ccos;
  alu_req_t           req;
  alu_rsp_t           rsp;
  logic signed [63:0] den;
  logic               skip;
  logic signed [31:0] res32;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {pos_q[3], pos_q[2], pos_q[1], pos_q[0]};
  assign m_axis_tuser  = {sat_q, sing_q};
  assign cstart        = (state_q == S_TRIG);
  assign res32         = rsp.res[31:0];

  // b2 + r*r, unclamped
  assign den = 64'(throat_q) + 64'(t_q);

  wge_cordic u_cordic (
    .clk_i, .rst_ni,
    .start_i(cstart), .theta_i(pos_q[1]),
    .done_o(cdone), .sin_o(csin), .cos_o(ccos)
  );

  wge_alu u_alu (.clk_i, .rst_ni, .req_i(req), .rsp_o(rsp));

  // operand selection for the current micro-op
  always_comb begin
    req.op    = OP_MUL;
    req.a     = '0;
    req.b     = '0;
    skip      = 1'b0;
    unique case (uop_q)
      U_S2:   begin req.a = 64'(sn_q); req.b = 64'(sn_q); end
      U_SC:   begin req.a = 64'(sn_q); req.b = 64'(cs_q); end
      U_RR:   begin req.a = 64'(pos_q[0]); req.b = 64'(pos_q[0]); end
      U_Q:    begin
        req.op = OP_DIV; req.a = 64'(pos_q[0]); req.b = den;
        skip = (den == 64'sd0);
      end
      U_COT:  begin
        req.op = OP_DIV; req.a = 64'(cs_q); req.b = 64'(sn_q);
        skip = (sn_q == 32'sd0);
      end
      U_VPH2: begin req.a = 64'(vel_q[2]); req.b = 64'(vel_q[2]); end
      U_VTH2: begin req.a = 64'(vel_q[1]); req.b = 64'(vel_q[1]); end
      U_S2V:  begin req.a = 64'(s2_q); req.b = 64'(vph2_q); end
      U_AR:   begin req.a = 64'(pos_q[0]); req.b = 64'(acc_q[0]); end
      U_SCV:  begin req.a = 64'(sc_q); req.b = 64'(vph2_q); end
      U_VRVT: begin req.a = 64'(vel_q[0]); req.b = 64'(vel_q[1]); end
      U_QA:   begin req.a = 64'(q_q); req.b = 64'(t_q); end
      U_VRVP: begin req.a = 64'(vel_q[0]); req.b = 64'(vel_q[2]); end
      U_QB:   begin req.a = 64'(q_q); req.b = 64'(t_q); end
      U_VTVP: begin req.a = 64'(vel_q[1]); req.b = 64'(vel_q[2]); end
      U_CB:   begin req.a = 64'(cot_q); req.b = 64'(t_q); end
      U_DV0:  begin req.a = 64'(acc_q[0]); req.b = 64'(step_q); end
      U_DV1:  begin req.a = 64'(acc_q[1]); req.b = 64'(step_q); end
      U_DV2:  begin req.a = 64'(acc_q[2]); req.b = 64'(step_q); end
      U_DP0:  begin req.a = 64'(vel_q[0]); req.b = 64'(step_q); end
      U_DP1:  begin req.a = 64'(vel_q[1]); req.b = 64'(step_q); end
      U_DP2:  begin req.a = 64'(vel_q[2]); req.b = 64'(step_q); end
      U_DP3:  begin req.a = 64'(vel_q[3]); req.b = 64'(step_q); end
      default: ;
    endcase
    // a skipped divide never reaches the shared unit
    req.start = (state_q == S_ISSUE) && !skip;
  end

  // wide sums of two 32-bit terms
  function automatic logic signed [63:0] sx(input logic signed [31:0] v);
    return 64'(v);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      uop_q    <= U_S2;
      throat_q <= ThroatResetVal;
      step_q   <= StepResetVal;
      ovalid_q <= 1'b0;
      sing_q   <= 1'b0;
      sat_q    <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_THROAT: throat_q <= cfg_data_i;
          CFG_STEP:   step_q   <= cfg_data_i[24:0];
        endcase
      end
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            sing_q <= 1'b0;
            sat_q  <= 1'b0;
            if (mode_e'(s_axis_tuser) == MODE_LOAD) begin
              for (int i = 0; i < 4; i++) begin
                pos_q[i] <= s_axis_tdata[32*i +: 32];
                vel_q[i] <= s_axis_tdata[128 + 32*i +: 32];
              end
              ovalid_q <= 1'b1;
            end else begin
              state_q <= S_TRIG;
            end
          end
        end
        S_TRIG: state_q <= S_CORDIC;
        S_CORDIC: begin
          if (cdone) begin
            sn_q    <= csin;
            cs_q    <= ccos;
            uop_q   <= U_S2;
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (skip) begin
            sing_q <= 1'b1;
            if (uop_q == U_Q) q_q <= '0;
            else cot_q <= '0;
            uop_q <= uop_e'(uop_q + 5'd1);
          end else begin
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (rsp.done) begin
            if (rsp.sat) sat_q <= 1'b1;
            state_q <= S_ISSUE;
            uop_q   <= uop_e'(uop_q + 5'd1);
            unique case (uop_q)
              U_S2:   s2_q <= res32;
              U_SC:   sc_q <= res32;
              U_RR:   t_q  <= res32;
              U_Q:    q_q  <= res32;
              U_COT:  cot_q <= res32;
              U_VPH2: vph2_q <= res32;
              U_VTH2: t_q <= res32;
              U_S2V: begin
                acc_q[0] <= clamp32(sx(t_q) + sx(res32));
                if (clamp_hit(sx(t_q) + sx(res32))) sat_q <= 1'b1;
              end
              U_AR:   acc_q[0] <= res32;
              // a_theta starts as sc*vph2
              U_SCV:  acc_q[1] <= res32;
              U_VRVT: t_q <= res32;
              U_QA: begin
                // a_theta = sc*vph2 - clamp(2*q*vr*vth)
                acc_q[1] <= clamp32(sx(acc_q[1]) - sx(clamp32(sx(res32) <<< 1)));
                if (clamp_hit(sx(res32) <<< 1) ||
                    clamp_hit(sx(acc_q[1]) - sx(clamp32(sx(res32) <<< 1))))
                  sat_q <= 1'b1;
              end
              U_VRVP: t_q <= res32;
              U_QB: begin
                // clamped 2*q*vr*vph, negated in the final sum
                acc_q[2] <= clamp32(sx(res32) <<< 1);
                if (clamp_hit(sx(res32) <<< 1)) sat_q <= 1'b1;
              end
              U_VTVP: t_q <= res32;
              U_CB: begin
                acc_q[2] <= clamp32(-sx(acc_q[2]) - sx(clamp32(sx(res32) <<< 1)));
                if (clamp_hit(sx(res32) <<< 1) ||
                    clamp_hit(-sx(acc_q[2]) - sx(clamp32(sx(res32) <<< 1))))
                  sat_q <= 1'b1;
              end
              U_DV0, U_DV1, U_DV2: begin
                vel_q[2'(uop_q - U_DV0)] <=
                  clamp32(sx(vel_q[2'(uop_q - U_DV0)]) + sx(res32));
                if (clamp_hit(sx(vel_q[2'(uop_q - U_DV0)]) + sx(res32))) sat_q <= 1'b1;
              end
              U_DP0, U_DP1, U_DP2, U_DP3: begin
                pos_q[2'(uop_q - U_DP0)] <=
                  clamp32(sx(pos_q[2'(uop_q - U_DP0)]) + sx(res32));
                if (clamp_hit(sx(pos_q[2'(uop_q - U_DP0)]) + sx(res32))) sat_q <= 1'b1;
                if (uop_q == U_DP3) begin
                  state_q  <= S_OUT;
                end
              end
              default: ;
            endcase
          end
        end
        S_OUT: begin
          ovalid_q <= 1'b1;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // no new request is taken while a result is pending
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while result pending");

  // a step never reaches the output stage before the shared unit finished
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> $past(rsp.done))
    else $error("step result without final update");

  // the cordic is started only from the trigger state
  a_cordic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cstart |=> (state_q == S_CORDIC))
    else $error("cordic start out of sequence");

endmodule

// ===== tb/wge_checker.sv =====
// checker for the wormhole geodesic step block: predicts each result and compares it
`timescale 1ns / 1ps
module wge_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [0:0]   cfg_index_i,
  input  logic [30:0]  cfg_data_i,
  input  logic         in_valid_i,
  input  logic         in_ready_i,
  input  logic [255:0] in_data_i,
  input  logic         in_user_i,
  input  logic         out_valid_i,
  input  logic         out_ready_i,
  input  logic [127:0] out_data_i,
  input  logic [1:0]   out_user_i,
  output int           fail_count_o,
  output int           pending_o
);
  import wge_pkg::*;

  typedef struct packed {
    logic [3:0][31:0] pos;
    logic             singular;
    logic             saturated;
  } ray_out_t;

  localparam longint S32Max = 64'sd2147483647;
  localparam longint S32Min = -64'sd2147483648;

  longint   atan_tab [30] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

  longint   b2_reg;
  longint   dt_reg;
  longint   pos_st [4];
  longint   vel_st [4];
  bit       clip_seen;
  ray_out_t expected_pos_q [$];

  function automatic longint sat32(longint v);
    if (v > S32Max) begin
      clip_seen = 1'b1;
      return S32Max;
    end
    if (v < S32Min) begin
      clip_seen = 1'b1;
      return S32Min;
    end
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return sat32((a * b) >>> FracBits);
  endfunction

  function automatic longint qdiv(longint num, longint den);
    return sat32((num * (64'sd1 <<< FracBits)) / den);
  endfunction

  function automatic void theta_sin_cos(input longint th, output longint sn,
                                        output longint cs);
    longint z, x, y, xs, ys;
    bit     flip;
    z = (th * (64'sd1 <<< Q30Shift)) % longint'(TwoPiQ30);
    x = longint'(GainQ30);
    y = 0;
    flip = 1'b0;
    if (z > longint'(PiQ30)) z -= longint'(TwoPiQ30);
    if (z < -longint'(PiQ30)) z += longint'(TwoPiQ30);
    if (z > longint'(HalfPiQ30)) begin
      z -= longint'(PiQ30);
      flip = 1'b1;
    end else if (z < -longint'(HalfPiQ30)) begin
      z += longint'(PiQ30);
      flip = 1'b1;
    end
    for (int i = 0; i < CordicN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_tab[i];
      end else begin
        x += ys; y -= xs; z += atan_tab[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    sn = (y + (64'sd1 <<< (Q30Shift - 1))) >>> Q30Shift;
    cs = (x + (64'sd1 <<< (Q30Shift - 1))) >>> Q30Shift;
  endfunction

  // one item: load or euler step, returns the emitted position and flags
  function automatic ray_out_t advance_ray(logic [255:0] data, logic mode);
    ray_out_t res;
    longint r, vr, vth, vph, sn, cs, s2, sc, q, cot, den, vph2;
    longint acc [4];
    res.singular = 1'b0;
    clip_seen = 1'b0;
    if (mode_e'(mode) == MODE_LOAD) begin
      for (int i = 0; i < 4; i++) begin
        pos_st[i] = longint'($signed(data[32*i +: 32]));
        vel_st[i] = longint'($signed(data[32*(i+4) +: 32]));
      end
    end else begin
      r = pos_st[0]; vr = vel_st[0]; vth = vel_st[1]; vph = vel_st[2];
      q = 0; cot = 0;
      theta_sin_cos(pos_st[1], sn, cs);
      s2 = qmul(sn, sn);
      sc = qmul(sn, cs);
      den = b2_reg + qmul(r, r);
      if (den == 0) res.singular = 1'b1;
      else q = qdiv(r, den);
      if (sn == 0) res.singular = 1'b1;
      else cot = qdiv(cs, sn);
      vph2 = qmul(vph, vph);
      acc[0] = qmul(r, sat32(qmul(vth, vth) + qmul(s2, vph2)));
      acc[1] = sat32(qmul(sc, vph2) - sat32(2 * qmul(q, qmul(vr, vth))));
      acc[2] = sat32(-sat32(2 * qmul(q, qmul(vr, vph)))
                     - sat32(2 * qmul(cot, qmul(vth, vph))));
      acc[3] = 0;
      for (int i = 0; i < 4; i++) vel_st[i] = sat32(vel_st[i] + qmul(acc[i], dt_reg));
      for (int i = 0; i < 4; i++) pos_st[i] = sat32(pos_st[i] + qmul(vel_st[i], dt_reg));
    end
    for (int i = 0; i < 4; i++) res.pos[i] = pos_st[i][31:0];
    res.saturated = clip_seen;
    return res;
  endfunction

  assign pending_o = expected_pos_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    ray_out_t exp_r;
    if (!rst_ni) begin
      b2_reg = longint'(ThroatResetVal);
      dt_reg = longint'(StepResetVal);
      for (int i = 0; i < 4; i++) begin
        pos_st[i] = 0;
        vel_st[i] = 0;
      end
      expected_pos_q.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_idx_e'(cfg_index_i) == CFG_THROAT) b2_reg = longint'(cfg_data_i);
        else if (cfg_idx_e'(cfg_index_i) == CFG_STEP) dt_reg = longint'(cfg_data_i[24:0]);
      end
      if (in_valid_i && in_ready_i)
        expected_pos_q.push_back(advance_ray(in_data_i, in_user_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_pos_q.size() == 0) begin
          $display("%0t: unexpected result %h flags %b", $time, out_data_i, out_user_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_pos_q.pop_front();
          if ({exp_r.pos[3], exp_r.pos[2], exp_r.pos[1], exp_r.pos[0]} !== out_data_i ||
              {exp_r.saturated, exp_r.singular} !== out_user_i) begin
            $display("%0t: mismatch expected pos %h %h %h %h sing %b sat %b", $time,
                     exp_r.pos[0], exp_r.pos[1], exp_r.pos[2], exp_r.pos[3],
                     exp_r.singular, exp_r.saturated);
            $display("%0t:          actual   pos %h %h %h %h sing %b sat %b", $time,
                     out_data_i[31:0], out_data_i[63:32], out_data_i[95:64],
                     out_data_i[127:96], out_user_i[0], out_user_i[1]);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/wormhole_geodesic_euler_step_top_tb.sv =====
// testbench top for the wormhole geodesic step block: stimulus, idling and verdict
`timescale 1ns / 1ps
module wormhole_geodesic_euler_step_top_tb;
  import wge_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int SettleCycles = 400;
  localparam int RandomItems = 1130;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [0:0]   cfg_index_i;
  logic [30:0]  cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata;   // r, theta, phi, ct, vr, vtheta, vphi, vt
  logic         s_axis_tuser;   // mode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;   // r, theta, phi, ct
  logic [1:0]   m_axis_tuser;   // singular, saturated

  int fail_count;
  int pending;
  int cycle_count = 0;
  int tx_idle_pct;
  int rx_idle_pct;
  bit rx_hold_req;
  bit rx_hold_done;

  wormhole_geodesic_euler_step_top u_top (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  wge_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i(s_axis_tvalid), .in_ready_i(s_axis_tready),
    .in_data_i(s_axis_tdata), .in_user_i(s_axis_tuser),
    .out_valid_i(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_i(m_axis_tdata), .out_user_i(m_axis_tuser),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("wormhole_geodesic_euler_step_top_tb NOT OK");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  always @(posedge clk_i) begin
    if (rx_hold_req && !rx_hold_done) begin
      m_axis_tready <= 1'b0;
      repeat (600) @(posedge clk_i);
      rx_hold_done = 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // mixes full-range words, small physical values and the extremes
  function automatic logic [31:0] pick_q824();
    unique case ($urandom_range(5))
      0:       return $urandom();
      1:       return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      2:       return 32'($signed($urandom_range(8 << 24)) - (4 << 24));
      default: return 32'($signed($urandom_range(64 << 24)) - (32 << 24));
    endcase
  endfunction

  // one request on the input stream, with random gaps ahead of it
  task automatic send_ray(mode_e mode, logic [255:0] data);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic load_ray(logic [31:0] r, logic [31:0] th, logic [31:0] ph, logic [31:0] ct,
                          logic [31:0] vr, logic [31:0] vth, logic [31:0] vph,
                          logic [31:0] vt);
    send_ray(MODE_LOAD, {vt, vph, vth, vr, ct, ph, th, r});
  endtask

  // step items carry random junk in the load fields, it must be ignored
  task automatic step_ray();
    send_ray(MODE_STEP, {$urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom(), $urandom()});
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // steps are long; let the last one settle fully
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [30:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [30:0] b2_set;
    logic [30:0] dt_set;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_THROAT;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_LOAD;
    rx_hold_req   = 1'b0;
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset state, zero sine, extremes, saturating velocities
    step_ray();
    load_ray(32'h0100_0000 * 5, 32'h0192_2000, 0, 0, 32'hFF00_0000, 32'h0010_0000,
             32'h0020_0000, 32'h0100_0000);
    repeat (4) step_ray();
    load_ray(32'h0300_0000, 0, 32'h0100_0000, 0, 32'h0100_0000, 32'h0080_0000,
             32'h0040_0000, 32'h0100_0000);
    step_ray();
    load_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
             32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    repeat (2) step_ray();
    load_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
             32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    repeat (2) step_ray();
    load_ray(32'h0324_3F6A, 32'h0324_3F6A, 0, 0, 32'h0400_0000, 32'h0400_0000,
             32'h0400_0000, 0);
    step_ray();
    drain();
    // zero denominator: no throat and the ray sits at r = 0
    write_reg(CFG_THROAT, '0);
    write_reg(CFG_STEP, 31'h7FFF_FFFF);
    load_ray(0, 32'h0080_0000, 0, 0, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000,
             32'h0100_0000);
    repeat (2) step_ray();
    drain();
    write_reg(CFG_THROAT, 31'h7FFF_FFFF);
    write_reg(CFG_STEP, 31'(1 << 24));
    load_ray(32'h0200_0000, 32'h0150_0000, 0, 0, 32'h0100_0000, 32'h0080_0000,
             32'h0080_0000, 32'h0100_0000);
    repeat (2) step_ray();
    drain();

    // random: short trajectories from random loads, settings change per block
    for (int n = 0; n < RandomItems; n++) begin
      if (n < RandomItems / 3) begin
        tx_idle_pct = 15; rx_idle_pct = 87;
      end else if (n < 2 * RandomItems / 3) begin
        tx_idle_pct = 87; rx_idle_pct = 15;
      end else begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end
      if (n % 100 == 0) begin
        drain();
        unique case ((n / 100) % 6)
          0: begin b2_set = ThroatResetVal;  dt_set = 31'(StepResetVal); end
          1: begin b2_set = '0;              dt_set = '0;             end
          2: begin b2_set = 31'h7FFF_FFFF;   dt_set = 31'(1 << 24);   end
          3: begin b2_set = 31'($urandom()); dt_set = 31'($urandom()); end
          4: begin
            b2_set = 31'($urandom_range(1 << 28)); dt_set = 31'h7FFF_FFFF;
          end
          default: begin
            b2_set = 31'($urandom_range(1 << 26)); dt_set = 31'($urandom_range(1 << 22));
          end
        endcase
        write_reg(CFG_THROAT, b2_set);
        write_reg(CFG_STEP, dt_set);
      end
      if (n == 50) rx_hold_req = 1'b1;
      if (n == 500) drain();
      if ($urandom_range(99) < 15 || n % 100 == 0)
        load_ray(pick_q824(), pick_q824(), pick_q824(), pick_q824(),
                 pick_q824(), pick_q824(), pick_q824(), pick_q824());
      else
        step_ray();
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("wormhole_geodesic_euler_step_top_tb OK");
    end else begin
      $display("wormhole_geodesic_euler_step_top_tb NOT OK");
    end
    $finish;
  end

endmodule
